// ===== hw/rtl/uew_pkg.sv =====
// ----------------------------------------------------------------------------
// uew_pkg
// Types and constants shared by the USB enumeration watchdog.
// ----------------------------------------------------------------------------
package uew_pkg;

    localparam int CFG_W = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRACE    = 2'd0;
    localparam logic [1:0] CFG_STALL    = 2'd1;
    localparam logic [1:0] CFG_COOLDOWN = 2'd2;

    localparam logic [CFG_W-1:0] GRACE_RST    = 16'd4000;
    localparam logic [CFG_W-1:0] STALL_RST    = 16'd3000;
    localparam logic [CFG_W-1:0] COOLDOWN_RST = 16'd4000;

    // Event codes
    localparam logic [3:0] FN_TICK       = 4'd0;
    localparam logic [3:0] FN_WATCH      = 4'd1;
    localparam logic [3:0] FN_HOST_START = 4'd2;
    localparam logic [3:0] FN_HOST_STOP  = 4'd3;
    localparam logic [3:0] FN_ATTACH     = 4'd4;
    localparam logic [3:0] FN_REMOVE     = 4'd5;
    localparam logic [3:0] FN_CONFIGURED = 4'd6;
    localparam logic [3:0] FN_UNMOUNTED  = 4'd7;
    localparam logic [3:0] FN_IFACE_OPEN = 4'd8;
    localparam logic [3:0] FN_RESET_DONE = 4'd9;

    // Descriptor poll results
    localparam logic [1:0] KIND_ADDRESSED = 2'd1;
    localparam logic [1:0] KIND_MOUNTED   = 2'd2;

    // Actions
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_RESET  = 2'd1;
    localparam logic [1:0] ACT_RESUME = 2'd2;

    // Progress steps
    localparam logic [2:0] PG_NONE    = 3'd0;
    localparam logic [2:0] PG_ATTACH  = 3'd1;
    localparam logic [2:0] PG_DEVDESC = 3'd2;
    localparam logic [2:0] PG_SETADDR = 3'd3;
    localparam logic [2:0] PG_IFACE   = 3'd5;
    localparam logic [2:0] PG_MOUNT   = 3'd6;

    // Lifecycle codes as reported on the result channel
    localparam logic [2:0] LC_DISC    = 3'd0;
    localparam logic [2:0] LC_GRACE   = 3'd1;
    localparam logic [2:0] LC_ENUM    = 3'd2;
    localparam logic [2:0] LC_MOUNTED = 3'd3;
    localparam logic [2:0] LC_FAILED  = 3'd4;
    localparam logic [2:0] LC_RECWAIT = 3'd5;

    typedef enum logic [5:0] {
        L_DISC    = 6'b000001,
        L_GRACE   = 6'b000010,
        L_ENUM    = 6'b000100,
        L_MOUNTED = 6'b001000,
        L_FAILED  = 6'b010000,
        L_RECWAIT = 6'b100000
    } life_t;

    typedef struct packed {
        logic [3:0]  func;
        logic        root_present;
        logic        device_configured;
        logic [1:0]  poll_kind;
        logic [6:0]  device_addr;
        logic [15:0] vendor_id;
        logic [15:0] product_id;
    } evt_t;

    typedef struct packed {
        logic [6:0]  seen_addr;
        logic [15:0] seen_product;
        logic [15:0] seen_vendor;
        logic        recovery_done_flag;
        logic [2:0]  progress;
        logic [2:0]  life_state;
        logic [1:0]  action;
    } res_t;

    typedef struct packed {
        logic [CFG_W-1:0] grace_ticks;
        logic [CFG_W-1:0] stall_ticks;
        logic [CFG_W-1:0] cooldown_ticks;
    } cfg_t;

    function automatic logic [2:0] life_code(life_t st);
        logic [2:0] code;
        unique case (st)
            L_DISC:    code = LC_DISC;
            L_GRACE:   code = LC_GRACE;
            L_ENUM:    code = LC_ENUM;
            L_MOUNTED: code = LC_MOUNTED;
            L_FAILED:  code = LC_FAILED;
            L_RECWAIT: code = LC_RECWAIT;
            default:   code = LC_DISC;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/uew_core.sv =====
// ----------------------------------------------------------------------------
// uew_core
// Lifecycle state, progress and timers; one event applied per enabled cycle.
// ----------------------------------------------------------------------------
module uew_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  uew_pkg::evt_t evt,
    input  uew_pkg::cfg_t cfg,
    output uew_pkg::res_t res_next
);

    localparam int CMP_W = (TIMER_BITS > uew_pkg::CFG_W) ? TIMER_BITS : uew_pkg::CFG_W;

    typedef struct packed {
        uew_pkg::life_t        cs;
        logic [2:0]            ls;
        logic [TIMER_BITS-1:0] tis;
        logic [TIMER_BITS-1:0] tss;
        logic                  ru;
        logic                  rs;
        logic                  att;
        logic [15:0]           kv;
        logic [15:0]           kp;
        logic [6:0]            ka;
    } ctx_t;

    ctx_t       ctx_reg;
    ctx_t       ctx_next;
    logic [1:0] act;

    function automatic ctx_t move_to(ctx_t c, uew_pkg::life_t st);
        ctx_t r;
        r = c;
        if (r.cs != st) begin
            r.cs  = st;
            r.tis = '0;
        end
        return r;
    endfunction

    function automatic ctx_t record_step(ctx_t c, logic [2:0] p);
        ctx_t r;
        r     = c;
        r.ls  = p;
        r.tss = '0;
        if ((r.cs == uew_pkg::L_GRACE || r.cs == uew_pkg::L_RECWAIT ||
             r.cs == uew_pkg::L_FAILED || r.cs == uew_pkg::L_DISC) &&
            p >= uew_pkg::PG_ATTACH && p <= uew_pkg::PG_IFACE) begin
            r    = move_to(r, uew_pkg::L_ENUM);
            r.rs = 1'b0;
        end
        return r;
    endfunction

    function automatic ctx_t clear_cycle(ctx_t c);
        ctx_t r;
        r     = c;
        r.ls  = uew_pkg::PG_NONE;
        r.tss = '0;
        r.ru  = 1'b0;
        r.rs  = 1'b0;
        r.att = 1'b0;
        r.kv  = '0;
        r.kp  = '0;
        r.ka  = '0;
        return r;
    endfunction

    function automatic ctx_t poll_progress(ctx_t c, uew_pkg::evt_t e);
        ctx_t r;
        r = c;
        if (e.poll_kind == uew_pkg::KIND_MOUNTED) begin
            if (r.cs != uew_pkg::L_MOUNTED) begin
                r.kv = e.vendor_id;
                r.kp = e.product_id;
                r.ka = e.device_addr;
                r    = record_step(r, uew_pkg::PG_MOUNT);
                r    = move_to(r, uew_pkg::L_MOUNTED);
            end
        end else if (e.poll_kind == uew_pkg::KIND_ADDRESSED) begin
            if (e.vendor_id != r.kv || e.product_id != r.kp ||
                r.ls < uew_pkg::PG_DEVDESC) begin
                r.kv = e.vendor_id;
                r.kp = e.product_id;
                r.ka = e.device_addr;
                if (r.ls < uew_pkg::PG_SETADDR) begin
                    r = record_step(r, uew_pkg::PG_SETADDR);
                end
                r = record_step(r, uew_pkg::PG_DEVDESC);
            end
        end
        return r;
    endfunction

    always_comb begin
        ctx_t c;
        c   = ctx_reg;
        act = uew_pkg::ACT_NONE;
        unique case (evt.func)
            uew_pkg::FN_TICK: begin
                if (c.tis != '1) c.tis = c.tis + 1'b1;
                if (c.tss != '1) c.tss = c.tss + 1'b1;
            end
            uew_pkg::FN_WATCH: begin
                if (!evt.root_present) begin
                    if (c.cs != uew_pkg::L_DISC) begin
                        c = clear_cycle(c);
                        c = move_to(c, uew_pkg::L_DISC);
                    end
                end else if (c.cs == uew_pkg::L_DISC) begin
                    c     = move_to(c, uew_pkg::L_GRACE);
                    c.tss = '0;
                end else if (evt.device_configured) begin
                    if (c.cs != uew_pkg::L_MOUNTED) c = poll_progress(c, evt);
                end else begin
                    c = poll_progress(c, evt);
                    if (c.cs == uew_pkg::L_MOUNTED) begin
                        act = uew_pkg::ACT_NONE;
                    end else if (c.cs == uew_pkg::L_GRACE) begin
                        if (CMP_W'(c.tis) < CMP_W'(cfg.grace_ticks)) begin
                            act = uew_pkg::ACT_NONE;
                        end else if (!c.att && c.ls == uew_pkg::PG_NONE && !c.ru) begin
                            act = uew_pkg::ACT_RESET;
                        end else begin
                            c = move_to(c, uew_pkg::L_ENUM);
                        end
                    end else begin
                        // An enumeration stall with the reset spent drops into
                        // the failed handling below in the same event.
                        if (c.cs == uew_pkg::L_ENUM) begin
                            if (c.ls == uew_pkg::PG_NONE) begin
                                if (CMP_W'(c.tss) >= CMP_W'(cfg.grace_ticks) && !c.ru)
                                    act = uew_pkg::ACT_RESET;
                            end else if (CMP_W'(c.tss) < CMP_W'(cfg.stall_ticks)) begin
                                act = uew_pkg::ACT_NONE;
                            end else if (!c.ru) begin
                                act = uew_pkg::ACT_RESET;
                            end else begin
                                c = move_to(c, uew_pkg::L_FAILED);
                            end
                        end
                        if (c.cs == uew_pkg::L_FAILED) begin
                            if (!c.rs) begin
                                c.rs = 1'b1;
                                act  = uew_pkg::ACT_RESUME;
                            end
                        end else if (c.cs == uew_pkg::L_RECWAIT) begin
                            if (CMP_W'(c.tis) >= CMP_W'(cfg.cooldown_ticks))
                                c = move_to(c, uew_pkg::L_FAILED);
                        end
                    end
                end
            end
            uew_pkg::FN_HOST_START: begin
                c = clear_cycle(c);
                if (evt.root_present) begin
                    c     = move_to(c, uew_pkg::L_GRACE);
                    c.tss = '0;
                end else begin
                    c = move_to(c, uew_pkg::L_DISC);
                end
            end
            uew_pkg::FN_HOST_STOP, uew_pkg::FN_REMOVE: begin
                c = clear_cycle(c);
                c = move_to(c, uew_pkg::L_DISC);
            end
            uew_pkg::FN_ATTACH: begin
                c.att = 1'b1;
                if (c.cs != uew_pkg::L_MOUNTED) begin
                    if (c.cs != uew_pkg::L_ENUM) begin
                        c.ru = 1'b0;
                        c.rs = 1'b0;
                    end
                    c = record_step(c, uew_pkg::PG_ATTACH);
                    c = move_to(c, uew_pkg::L_ENUM);
                end
            end
            uew_pkg::FN_CONFIGURED: begin
                c.kv = evt.vendor_id;
                c.kp = evt.product_id;
                c.ka = evt.device_addr;
                c    = record_step(c, uew_pkg::PG_MOUNT);
                c    = move_to(c, uew_pkg::L_MOUNTED);
                c.ru = 1'b0;
            end
            uew_pkg::FN_UNMOUNTED: begin
                if (c.cs == uew_pkg::L_MOUNTED) begin
                    c.ls  = uew_pkg::PG_NONE;
                    c.tss = '0;
                    c     = move_to(c, uew_pkg::L_GRACE);
                    c.rs  = 1'b0;
                end
            end
            uew_pkg::FN_IFACE_OPEN: begin
                c = record_step(c, uew_pkg::PG_IFACE);
            end
            uew_pkg::FN_RESET_DONE: begin
                // kept address survives the recovery reset
                c.ru  = 1'b1;
                c.att = 1'b0;
                c.ls  = uew_pkg::PG_NONE;
                c.tss = '0;
                c.kv  = '0;
                c.kp  = '0;
                c     = move_to(c, uew_pkg::L_RECWAIT);
            end
            default: begin
                c = ctx_reg;
            end
        endcase
        ctx_next = c;
    end

    always_comb begin
        res_next.action             = act;
        res_next.life_state         = uew_pkg::life_code(ctx_next.cs);
        res_next.progress           = ctx_next.ls;
        res_next.recovery_done_flag = ctx_next.ru;
        res_next.seen_vendor        = ctx_next.kv;
        res_next.seen_product       = ctx_next.kp;
        res_next.seen_addr          = ctx_next.ka;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.cs  <= uew_pkg::L_DISC;
            ctx_reg.ls  <= uew_pkg::PG_NONE;
            ctx_reg.tis <= '0;
            ctx_reg.tss <= '0;
            ctx_reg.ru  <= 1'b0;
            ctx_reg.rs  <= 1'b0;
            ctx_reg.att <= 1'b0;
            ctx_reg.kv  <= '0;
            ctx_reg.kp  <= '0;
            ctx_reg.ka  <= '0;
        end else if (step_en) begin
            ctx_reg <= ctx_next;
        end
    end

endmodule

// ===== hw/rtl/usb_enum_watchdog_fsm.sv =====
// ----------------------------------------------------------------------------
// usb_enum_watchdog_fsm
// USB host enumeration watchdog: one event in, one action and status out.
// ----------------------------------------------------------------------------
//
//  channel   | direction | content                                | width
//  ----------+-----------+----------------------------------------+------
//  s_axis    | in        | event code (tuser), poll data (tdata)  | 4/48
//  m_axis    | out       | action and lifecycle snapshot (tdata)  | 48
//  cfg       | in        | grace / stall / cooldown windows       | 16
//
//  One transfer per cycle sustained on both channels while m_axis_tready stays
//  high; each event yields one result, held first in the input register and
//  then in the result register. The single state update step sets the rate.
//  Reset (aresetn low, synchronous) returns the lifecycle to disconnected,
//  clears both timers and all kept identifiers, and loads the default windows.
//  A stalled result register holds the input register, which then drops
//  s_axis_tready; events already in flight are never lost or repeated.
//
module usb_enum_watchdog_fsm #(
    parameter int TIMER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // root_present[0], device_configured[1], poll_kind[3:2],
    // device_addr[10:4], vendor_id[26:11], product_id[42:27], zero pad[47:43]
    input  logic [47:0] s_axis_tdata,
    // func[3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // action[1:0], life_state[4:2], progress[7:5], recovery_done_flag[8],
    // seen_vendor[24:9], seen_product[40:25], seen_addr[47:41]
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic          in_valid_reg;
    logic          in_valid_next;
    uew_pkg::evt_t in_item_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    uew_pkg::res_t out_res_reg;
    uew_pkg::res_t res_next;
    uew_pkg::cfg_t cfg_reg;
    logic          s_xfer;
    logic          advance;

    // The held event moves into the result register whenever that register
    // is empty or its transfer completes this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (s_xfer)       in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;
        else              in_valid_next = in_valid_reg;

        if (advance)            out_valid_next = 1'b1;
        else if (m_axis_tready) out_valid_next = 1'b0;
        else                    out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.func              <= s_axis_tuser;
            in_item_reg.root_present      <= s_axis_tdata[0];
            in_item_reg.device_configured <= s_axis_tdata[1];
            in_item_reg.poll_kind         <= s_axis_tdata[3:2];
            in_item_reg.device_addr       <= s_axis_tdata[10:4];
            in_item_reg.vendor_id         <= s_axis_tdata[26:11];
            in_item_reg.product_id        <= s_axis_tdata[42:27];
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    // Configuration; writes to an index beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grace_ticks    <= uew_pkg::GRACE_RST;
            cfg_reg.stall_ticks    <= uew_pkg::STALL_RST;
            cfg_reg.cooldown_ticks <= uew_pkg::COOLDOWN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                uew_pkg::CFG_GRACE:    cfg_reg.grace_ticks    <= cfg_wdata;
                uew_pkg::CFG_STALL:    cfg_reg.stall_ticks    <= cfg_wdata;
                uew_pkg::CFG_COOLDOWN: cfg_reg.cooldown_ticks <= cfg_wdata;
                default:               cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // State engine: updates lifecycle, progress and timers on each advance
    uew_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .evt      (in_item_reg),
        .cfg      (cfg_reg),
        .res_next (res_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.seen_addr, out_res_reg.seen_product,
                            out_res_reg.seen_vendor, out_res_reg.recovery_done_flag,
                            out_res_reg.progress, out_res_reg.life_state,
                            out_res_reg.action};

endmodule

// ===== hw/rtl/uew_checker.sv =====
// ----------------------------------------------------------------------------
// uew_checker
// Port-level checks on the enumeration watchdog, bound to the top level.
// ----------------------------------------------------------------------------
module uew_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // No result is offered straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Scans resume only from the failed state
    a_resume_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] == uew_pkg::ACT_RESUME
            |-> m_axis_tdata[4:2] == uew_pkg::LC_FAILED)
        else $error("resume outside failed state");

    // A port reset is asked for only while it is still unused, and only
    // while in grace or enumeration
    a_reset_once: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] == uew_pkg::ACT_RESET
            |-> !m_axis_tdata[8] &&
                (m_axis_tdata[4:2] == uew_pkg::LC_GRACE ||
                 m_axis_tdata[4:2] == uew_pkg::LC_ENUM))
        else $error("port reset requested after recovery used");

endmodule

bind usb_enum_watchdog_fsm uew_checker u_uew_checker (.*);
